[design/cte_pkg.sv]
// Shared types, constants and saturation helpers for the Chebyshev transfer evaluator.
// Used by cte_x_map, cte_cell and chebyshev_transfer_evaluator. No dependencies.
package cte_pkg;

  localparam int NUM_TERMS  = 6;
  localparam int INDEX_BITS = 16;
  localparam int SLOT_W     = 16;
  localparam int IDX_W      = (INDEX_BITS < SLOT_W) ? INDEX_BITS : SLOT_W;
  localparam int Q_W        = 24;
  localparam int SUM_W      = 32;
  localparam int STEP_W     = 32;
  localparam int WIDE_W     = 48;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_STEP   = 4'd0,
    CFG_X_OFFSET = 4'd1,
    CFG_COEF_0   = 4'd2
  } cfg_reg_t;

  typedef logic signed [Q_W-1:0]    q16_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q16_t ONE_Q16      = 24'sd65536;
  localparam q16_t X_OFFSET_RST = -24'sd65536;
  localparam q16_t COEF_1_RST   = 24'sd65536;

  localparam wide_t Q16_MAX_W = 48'sd8388607;
  localparam wide_t Q16_MIN_W = -48'sd8388608;
  localparam wide_t SUM_MAX_W = 48'sd2147483647;
  localparam wide_t SUM_MIN_W = -48'sd2147483648;

  typedef struct packed {
    q16_t x;
    q16_t t_prev;
    q16_t t_cur;
    sum_t sum;
    logic flag;
  } tap_t;

  typedef struct packed {
    logic first;
    logic recur;
  } cell_ctl_t;

  function automatic q16_t sat_q16(wide_t v);
    q16_t r;
    if (v > Q16_MAX_W) begin
      r = Q16_MAX_W[Q_W-1:0];
    end else if (v < Q16_MIN_W) begin
      r = Q16_MIN_W[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic over_q16(wide_t v);
    return (v > Q16_MAX_W) || (v < Q16_MIN_W);
  endfunction

  function automatic sum_t sat_sum(wide_t v);
    sum_t r;
    if (v > SUM_MAX_W) begin
      r = SUM_MAX_W[SUM_W-1:0];
    end else if (v < SUM_MIN_W) begin
      r = SUM_MIN_W[SUM_W-1:0];
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic over_sum(wide_t v);
    return (v > SUM_MAX_W) || (v < SUM_MIN_W);
  endfunction

  function automatic cell_ctl_t cell_ctl(int n);
    cell_ctl_t c;
    c.first = (n == 0);
    c.recur = (n >= 1) && (n + 1 < NUM_TERMS);
    return c;
  endfunction

endpackage

[design/cte_x_map.sv]
// Maps a slot index to x = index * x_step / 4096 + x_offset in two stages.
// Depends on cte_pkg; feeds the first cell of the term chain.
module cte_x_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cte_pkg::SLOT_W-1:0] in_slot_index,
  input  logic signed [cte_pkg::STEP_W-1:0] x_step,
  input  cte_pkg::q16_t              x_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cte_pkg::tap_t              out_tap
);
  import cte_pkg::*;

  localparam int PW = IDX_W + STEP_W + 1;
  localparam logic signed [PW-1:0] RND_X = PW'(2048);

  logic                 a_valid_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] x_rnd;
  logic signed [PW-1:0] x_sum;
  wide_t                x_wide;
  logic                 b_valid_r;
  tap_t                 tap_r;
  tap_t                 tap_nxt;
  logic                 a_en;
  logic                 b_en;

  assign b_en     = !b_valid_r || out_ready;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  assign prod_nxt = $signed({1'b0, in_slot_index[IDX_W-1:0]}) * x_step;

  assign x_rnd  = (prod_r + RND_X) >>> 12;
  assign x_sum  = x_rnd + PW'(x_offset);
  assign x_wide = WIDE_W'(x_sum);

  always_comb begin
    tap_nxt.x      = sat_q16(x_wide);
    tap_nxt.t_prev = ONE_Q16;
    tap_nxt.t_cur  = ONE_Q16;
    tap_nxt.sum    = '0;
    tap_nxt.flag   = over_q16(x_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      prod_r <= prod_nxt;
    end
    if (b_en) begin
      tap_r <= tap_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_tap   = tap_r;

endmodule

[design/cte_cell.sv]
// One term cell: weights T(n) into the sum; T(n+1) is x in cell 0, none in the last,
// else by the recurrence. Depends on cte_pkg; chained at top level, two stages each.
module cte_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cte_pkg::cell_ctl_t ctl,
  input  cte_pkg::q16_t      coef,
  input  logic               in_valid,
  output logic               in_ready,
  input  cte_pkg::tap_t      in_tap,
  output logic               out_valid,
  input  logic               out_ready,
  output cte_pkg::tap_t      out_tap
);
  import cte_pkg::*;

  logic  a_valid_r;
  tap_t  a_tap_r;
  wide_t psum_r;
  wide_t prec_r;
  logic  b_valid_r;
  tap_t  b_tap_r;
  tap_t  b_tap_nxt;
  wide_t psum_rnd;
  wide_t sum_new;
  wide_t prec_rnd;
  wide_t rec_new;
  logic  a_en;
  logic  b_en;

  assign b_en     = !b_valid_r || out_ready;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  // The doubling of 2*x*T(n) is folded into a rounding shift by one bit less.
  assign psum_rnd = (psum_r + 48'sd32768) >>> 16;
  assign sum_new  = psum_rnd + WIDE_W'($signed(a_tap_r.sum));
  assign prec_rnd = (prec_r + 48'sd16384) >>> 15;
  assign rec_new  = prec_rnd - WIDE_W'($signed(a_tap_r.t_prev));

  always_comb begin
    b_tap_nxt.x      = a_tap_r.x;
    b_tap_nxt.t_prev = a_tap_r.t_cur;
    if (ctl.first) begin
      b_tap_nxt.t_cur = a_tap_r.x;
    end else if (ctl.recur) begin
      b_tap_nxt.t_cur = sat_q16(rec_new);
    end else begin
      b_tap_nxt.t_cur = a_tap_r.t_cur;
    end
    b_tap_nxt.sum  = sat_sum(sum_new);
    b_tap_nxt.flag = a_tap_r.flag || over_sum(sum_new) ||
                     (ctl.recur && over_q16(rec_new));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_tap_r <= in_tap;
      psum_r  <= $signed(coef) * $signed(in_tap.t_cur);
      prec_r  <= $signed(in_tap.x) * $signed(in_tap.t_cur);
    end
    if (b_en) begin
      b_tap_r <= b_tap_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_tap   = b_tap_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && b_en) |=> b_valid_r)
    else $error("cell lost an item between its stages");

endmodule

[design/chebyshev_transfer_evaluator.sv]
// Chebyshev waveshaping transfer evaluator: one slot index in, one saturated Q16.16 value
// and a clip flag out. Depends on cte_pkg, cte_x_map and cte_cell.
//
// The block accepts one index per cycle unless the output stalls, and returns results in
// order. Two stages map the index to x, then each term cell spends one stage on its two
// 24x24 multiplies and one on rounding, the sum and the recurrence. Every stage holds its
// item only while the stage after it is full and stalled, so the chain keeps filling while
// a result waits at the output.
// Configuration registers are written with cfg_valid at any time and must only change
// while no item is in flight; there is no clearing pass after reset.
module chebyshev_transfer_evaluator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cte_pkg::SLOT_W-1:0]     in_slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [cte_pkg::SUM_W-1:0] out_table_value,
  output logic                           out_clipped,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cte_pkg::*;

  logic signed [STEP_W-1:0] x_step_r;
  q16_t                     x_offset_r;
  q16_t                     coef_r [NUM_TERMS];

  logic                     chain_valid [NUM_TERMS+1];
  logic                     chain_ready [NUM_TERMS+1];
  tap_t                     chain_tap   [NUM_TERMS+1];
  logic                     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_step_r   <= '0;
      x_offset_r <= X_OFFSET_RST;
      for (int i = 0; i < NUM_TERMS; i++) begin
        coef_r[i] <= (i == 1) ? COEF_1_RST : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_X_STEP) begin
        x_step_r <= cfg_data;
      end
      if (cfg_index == CFG_X_OFFSET) begin
        x_offset_r <= cfg_data[Q_W-1:0];
      end
      for (int i = 0; i < NUM_TERMS; i++) begin
        if (cfg_index == CFG_IDX_W'(CFG_COEF_0 + i)) begin
          coef_r[i] <= cfg_data[Q_W-1:0];
        end
      end
    end
  end

  cte_x_map u_x_map (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_slot_index (in_slot_index),
    .x_step        (x_step_r),
    .x_offset      (x_offset_r),
    .out_valid     (chain_valid[0]),
    .out_ready     (chain_ready[0]),
    .out_tap       (chain_tap[0])
  );

  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_cell
    cte_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl(g)),
      .coef      (coef_r[g]),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_tap    (chain_tap[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_tap   (chain_tap[g+1])
    );
  end

  assign chain_ready[NUM_TERMS] = out_ready;
  assign out_valid       = chain_valid[NUM_TERMS];
  assign out_table_value = chain_tap[NUM_TERMS].sum;
  assign out_clipped     = chain_tap[NUM_TERMS].flag;

  assert property (@(posedge clk) !rst_n |=> (x_offset_r == X_OFFSET_RST))
    else $error("x_offset not at its reset value after reset");

  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == CFG_X_STEP) |=> (x_step_r == $past(cfg_data)))
    else $error("x_step write was not taken");

endmodule

[tb/sv/chebyshev_transfer_evaluator_test.sv]
// Self-checking bench for chebyshev_transfer_evaluator: directed and random slot indices under
// several register settings, each result and clip flag checked against a fixed-point predictor.
// Depends on cte_pkg and the evaluator RTL.
`timescale 1ns / 100ps

module chebyshev_transfer_evaluator_test;
  import cte_pkg::*;

  localparam int COEF_COUNT  = 6;
  localparam int LATENCY     = 2 + 2 * NUM_TERMS;
  localparam int RUN_LIMIT   = 400000;
  localparam int PHASE_ITEMS = 225;
  localparam int MAX_REPORTS = 100;

  localparam longint Q_LO   = -64'sd8388608;
  localparam longint Q_HI   = 64'sd8388607;
  localparam longint SUM_LO = -64'sd2147483648;
  localparam longint SUM_HI = 64'sd2147483647;

  typedef struct packed {
    sum_t value;
    logic clipped;
  } transfer_entry_t;

  typedef enum int {
    SET_UNIT,
    SET_TYPICAL,
    SET_ALL_MAX,
    SET_ALL_MIN,
    SET_CORNER,
    SET_WILD
  } setting_kind_t;

  localparam setting_kind_t PHASE_PLAN [8] = '{
    SET_TYPICAL, SET_ALL_MAX, SET_TYPICAL, SET_ALL_MIN,
    SET_WILD, SET_TYPICAL, SET_CORNER, SET_TYPICAL
  };

  localparam int UNIT_COEFS [COEF_COUNT] = '{16384, 65536, -32768, 49152, -65536, 32768};

  localparam logic [SLOT_W-1:0] RESET_SLOTS [4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
  localparam logic [SLOT_W-1:0] EDGE_SLOTS [16] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
    16'h00FF, 16'hFF00, 16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1234, 16'hEDCB
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SLOT_W-1:0]     in_slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_table_value;
  logic                  out_clipped;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  longint step_reg = 0;
  longint offset_reg = -65536;
  longint coef_reg [COEF_COUNT] = '{0, 65536, 0, 0, 0, 0};

  logic [SLOT_W-1:0] slot_feed [$];
  transfer_entry_t   entries_due [$];

  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     failures = 0;
  int     items_queued = 0;
  int     items_sent = 0;
  int     results_seen = 0;
  int     clipped_seen = 0;
  int     settings_used = 0;
  longint cycles = 0;

  chebyshev_transfer_evaluator uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint round_half_up(longint v, int k);
    return (v + (64'sd1 << (k - 1))) >>> k;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi, inout logic hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic transfer_entry_t chebyshev_entry(logic [SLOT_W-1:0] slot);
    longint idx, x, t_prev, t_cur, t_next, acc;
    logic clip;
    transfer_entry_t entry;
    idx = 0;
    idx[IDX_W-1:0] = slot[IDX_W-1:0];
    clip = 1'b0;
    x = saturate(round_half_up(idx * step_reg, 12) + offset_reg, Q_LO, Q_HI, clip);
    t_prev = longint'(ONE_Q16);
    t_cur = x;
    acc = 0;
    for (int n = 0; n < NUM_TERMS; n++) begin
      acc = saturate(acc + round_half_up(coef_reg[n] * ((n == 0) ? t_prev : t_cur), 16),
                     SUM_LO, SUM_HI, clip);
      if (n >= 1 && n + 1 < NUM_TERMS) begin
        t_next = saturate(round_half_up(2 * x * t_cur, 16) - t_prev, Q_LO, Q_HI, clip);
        t_prev = t_cur;
        t_cur = t_next;
      end
    end
    entry.value = acc[SUM_W-1:0];
    entry.clipped = clip;
    return entry;
  endfunction

  // Writes every register, then one write to an unused index, which must change nothing.
  task automatic apply_setting(setting_kind_t kind);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    int   val;
    int   reg_no;
    logic is_step;
    q16_t narrow;
    sum_t full;
    for (reg_no = 0; reg_no <= COEF_COUNT + 2; reg_no++) begin
      is_step = (reg_no == CFG_X_STEP);
      case (kind)
        SET_UNIT: begin
          if (is_step) begin
            val = 8192;
          end else if (reg_no == CFG_X_OFFSET) begin
            val = -65536;
          end else if (reg_no < CFG_COEF_0 + COEF_COUNT) begin
            val = UNIT_COEFS[reg_no - CFG_COEF_0];
          end else begin
            val = 0;
          end
        end
        SET_TYPICAL: begin
          if (is_step) begin
            val = $urandom_range(8200, 1500);
          end else if (reg_no == CFG_X_OFFSET) begin
            val = -int'($urandom_range(65536, 32768));
          end else begin
            val = int'($urandom_range(196608, 0)) - 98304;
          end
        end
        SET_ALL_MAX: val = is_step ? 32'h7FFF_FFFF : 32'h007F_FFFF;
        SET_ALL_MIN: val = is_step ? 32'h8000_0000 : 32'hFF80_0000;
        SET_CORNER: begin
          if ($urandom_range(1, 0) == 1) begin
            val = is_step ? 32'h7FFF_FFFF : 32'h007F_FFFF;
          end else begin
            val = is_step ? 32'h8000_0000 : 32'hFF80_0000;
          end
        end
        default: val = $urandom;
      endcase
      data = $urandom;
      if (reg_no == COEF_COUNT + 2) begin
        idx = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_COEF_0 + COEF_COUNT));
      end else begin
        idx = CFG_IDX_W'(reg_no);
        if (is_step) begin
          data = val;
        end else begin
          data[Q_W-1:0] = val[Q_W-1:0];
        end
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      narrow = data[Q_W-1:0];
      full = data;
      if (idx == CFG_X_STEP) begin
        step_reg = longint'(full);
      end else if (idx == CFG_X_OFFSET) begin
        offset_reg = longint'(narrow);
      end else if (idx < CFG_COEF_0 + COEF_COUNT) begin
        coef_reg[idx - CFG_COEF_0] = longint'(narrow);
      end
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_slot(logic [SLOT_W-1:0] slot);
    slot_feed.push_back(slot);
    items_queued++;
  endtask

  task automatic drain();
    while (items_sent != items_queued || entries_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        entries_due.push_back(chebyshev_entry(in_slot_index));
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (slot_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_slot_index <= slot_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
          in_slot_index <= SLOT_W'($urandom);
        end
      end
    end
  end

  always @(posedge clk) begin
    transfer_entry_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (entries_due.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("%0t: result with nothing expected: value %0d clipped %0b", $time,
                     out_table_value, out_clipped);
          end
        end else begin
          want = entries_due.pop_front();
          results_seen++;
          if (want.clipped) begin
            clipped_seen++;
          end
          if (out_table_value !== want.value) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("%0t: table_value expected %0d actual %0d", $time, want.value,
                       out_table_value);
            end
          end
          if (out_clipped !== want.clipped) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("%0t: clipped expected %0b actual %0b", $time, want.clipped,
                       out_clipped);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results outstanding", $time,
               cycles, entries_due.size() + items_queued - items_sent);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (RESET_SLOTS[i]) begin
      queue_slot(RESET_SLOTS[i]);
    end
    drain();
    apply_setting(SET_UNIT);
    foreach (EDGE_SLOTS[i]) begin
      queue_slot(EDGE_SLOTS[i]);
    end
    drain();
    foreach (PHASE_PLAN[p]) begin
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 86;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 86;
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
        end
      endcase
      apply_setting(PHASE_PLAN[p]);
      repeat (PHASE_ITEMS) queue_slot(SLOT_W'($urandom_range(65535, 0)));
      drain();
    end
    $display("Sent %0d slot indices under %0d register settings;", items_sent, settings_used);
    $display("%0d results checked, %0d of them clipped.", results_seen, clipped_seen);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/cte_pkg.sv
design/cte_x_map.sv
design/cte_cell.sv
design/chebyshev_transfer_evaluator.sv
tb/sv/chebyshev_transfer_evaluator_test.sv
